// File: design/chp_pkg.sv
// Shared types and constants for the chunk header parser.
`timescale 1ns / 1ps
`default_nettype none

package chp_pkg;

    localparam int MAX_SECTIONS_DEF = 64;
    localparam int HEADER_LEN       = 8;
    localparam int INDEX_W          = 6;

    localparam logic STATUS_SECTION = 1'b0;
    localparam logic STATUS_OVERRUN = 1'b1;

    typedef struct packed {
        logic        start_req;
        logic [31:0] total_size;
        logic [7:0]  data_byte;
    } t_in_word;

    typedef struct packed {
        logic               status;
        logic [INDEX_W-1:0] section_index;
        logic [31:0]        tag;
        logic [31:0]        body_length;
        logic [31:0]        body_offset;
    } t_out_word;

    typedef struct packed {
        logic      push;
        t_out_word word;
    } t_result;

endpackage

`default_nettype wire

// File: design/chp_parse.sv
// Parse state and per-byte header, body-skip and overrun logic.
`timescale 1ns / 1ps
`default_nettype none

module chp_parse #(
    parameter int MAX_SECTIONS = chp_pkg::MAX_SECTIONS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire chp_pkg::t_in_word i_word,
    output chp_pkg::t_result       o_result
);

    localparam int CW = $clog2(MAX_SECTIONS + 1);

    logic [3:0]    r_pos,      n_pos;
    logic [31:0]   r_tag,      n_tag;
    logic [31:0]   r_len,      n_len;
    logic [31:0]   r_body,     n_body;
    logic [32:0]   r_consumed, n_consumed;
    logic [31:0]   r_buf_len,  n_buf_len;
    logic [CW-1:0] r_count,    n_count;
    logic          r_halted,   n_halted;

    logic [32:0] hdr_end;
    logic [33:0] body_end;

    always_comb begin
        n_pos      = r_pos;
        n_tag      = r_tag;
        n_len      = r_len;
        n_body     = r_body;
        n_consumed = r_consumed;
        n_buf_len  = r_buf_len;
        n_count    = r_count;
        n_halted   = r_halted;
        hdr_end    = '0;
        body_end   = '0;
        o_result   = '0;

        if (i_accept) begin
            if (i_word.start_req) begin
                n_pos      = '0;
                n_tag      = '0;
                n_len      = '0;
                n_body     = '0;
                n_consumed = '0;
                n_count    = '0;
                n_buf_len  = i_word.total_size;
                n_halted   = 1'b0;
            end
            if (!n_halted) begin
                if (n_body != '0) begin
                    n_body = n_body - 32'd1;
                end else begin
                    if (n_pos == '0) begin
                        if (n_consumed >= {1'b0, n_buf_len} || n_count >= CW'(MAX_SECTIONS))
                        begin
                            n_halted = 1'b1;
                        end
                        n_tag = '0;
                        n_len = '0;
                    end
                    if (!n_halted) begin
                        if (!n_pos[2]) begin
                            n_tag = n_tag | (32'(i_word.data_byte) << {n_pos[1:0], 3'b000});
                        end else begin
                            n_len = n_len | (32'(i_word.data_byte) << {n_pos[1:0], 3'b000});
                        end
                        n_pos = n_pos + 4'd1;
                        if (n_pos == 4'(chp_pkg::HEADER_LEN)) begin
                            n_pos    = '0;
                            hdr_end  = n_consumed + 33'(chp_pkg::HEADER_LEN);
                            body_end = {1'b0, hdr_end} + {2'b00, n_len};
                            o_result.push               = 1'b1;
                            o_result.word.section_index = chp_pkg::INDEX_W'(n_count);
                            o_result.word.tag           = n_tag;
                            o_result.word.body_length   = n_len;
                            o_result.word.body_offset   = hdr_end[31:0];
                            if (body_end > {2'b00, n_buf_len}) begin
                                o_result.word.status = chp_pkg::STATUS_OVERRUN;
                                n_consumed           = hdr_end;
                                n_halted             = 1'b1;
                            end else begin
                                o_result.word.status = chp_pkg::STATUS_SECTION;
                                n_count              = n_count + CW'(1);
                                n_body               = n_len;
                                n_consumed           = body_end[32:0];
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_tag      <= '0;
            r_len      <= '0;
            r_body     <= '0;
            r_consumed <= '0;
            r_buf_len  <= '0;
            r_count    <= '0;
            r_halted   <= 1'b1;
        end else begin
            r_pos      <= n_pos;
            r_tag      <= n_tag;
            r_len      <= n_len;
            r_body     <= n_body;
            r_consumed <= n_consumed;
            r_buf_len  <= n_buf_len;
            r_count    <= n_count;
            r_halted   <= n_halted;
        end
    end

endmodule

`default_nettype wire

// File: design/chp_out_buf.sv
// Result register with a skid stage for the output channel.
`timescale 1ns / 1ps
`default_nettype none

module chp_out_buf (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire chp_pkg::t_result   i_result,
    output logic                    o_full,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output chp_pkg::t_out_word      o_out_word
);

    logic               r_out_valid;
    logic               r_skid_valid;
    chp_pkg::t_out_word r_out_word;
    chp_pkg::t_out_word r_skid_word;
    logic               pop;

    assign pop         = r_out_valid && !i_out_stall;
    assign o_full      = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_out_word   <= r_skid_word;
                r_skid_valid <= 1'b0;
            end
        end else if (i_result.push) begin
            if (!r_out_valid || pop) begin
                r_out_word  <= i_result.word;
                r_out_valid <= 1'b1;
            end else begin
                r_skid_word  <= i_result.word;
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

`default_nettype wire

// File: design/chunk_header_parser.sv
// Top level of the chunk header parser: byte input, section/overrun record output.
// A header's record is registered in the result register or skid stage.
// Throughput: one byte per cycle; the state update, with its end-of-body add and
// compare against the buffer length, completes in the cycle a byte is taken.
// Input stalls only while both the result register and skid stage are full.
// Reset (synchronous, active low) halts parsing until a start word; outputs empty.
`timescale 1ns / 1ps
`default_nettype none

module chunk_header_parser #(
    parameter int MAX_SECTIONS = chp_pkg::MAX_SECTIONS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire chp_pkg::t_in_word  i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output chp_pkg::t_out_word      o_out_word
);

    logic             accept;
    chp_pkg::t_result result;

    assign accept = i_in_valid && !o_in_stall;

    chp_parse #(
        .MAX_SECTIONS(MAX_SECTIONS)
    ) u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_word   (i_in_word),
        .o_result (result)
    );

    chp_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_result    (result),
        .o_full      (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    // a record is only produced from an accepted word
    a_push_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        result.push |-> accept)
        else $error("record produced without an accepted word");

    // skid stage never holds a word with the result register empty
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("skid stage full while output empty");

    // a new record with the output stalled must fill the skid stage
    a_push_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        result.push && o_out_valid && i_out_stall |=> o_in_stall && o_out_valid)
        else $error("record lost while output stalled");

endmodule

`default_nettype wire
